>>> rtl/fms_pkg.sv
// Shared constants and types for the flight-mode sequencer.
`timescale 1ns / 1ps

package fms_pkg;

  // Flight phase codes.
  localparam logic [7:0] PH_DISARMED      = 8'd0;
  localparam logic [7:0] PH_ARMED         = 8'd1;
  localparam logic [7:0] PH_MISALIGN      = 8'd2;
  localparam logic [7:0] PH_GUIDANCE      = 8'd3;
  localparam logic [7:0] PH_RETURN_VERT   = 8'd4;
  localparam logic [7:0] PH_PAST_APOGEE   = 8'd5;
  localparam logic [7:0] PH_LANDING_BURN  = 8'd6;
  localparam logic [7:0] PH_LANDED        = 8'd7;
  localparam logic [7:0] PH_TEST_FIRST    = 8'd64;
  localparam logic [7:0] PH_TEST_LAST     = 8'd68;

  // Command status codes.
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_BAD_STATE      = 3'd1;
  localparam logic [2:0] ST_BAD_TRANSITION = 3'd2;
  localparam logic [2:0] ST_BAD_SENSORS    = 3'd3;
  localparam logic [2:0] ST_NO_CONTINUITY  = 3'd4;

  // Item kinds.
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MISALIGN_TIME = 3'd0;
  localparam logic [2:0] CFG_STAB_TIME     = 3'd1;
  localparam logic [2:0] CFG_LANDED_TIME   = 3'd2;
  localparam logic [2:0] CFG_APOGEE_DROP   = 3'd3;
  localparam logic [2:0] CFG_PYRO_LOCKOUT  = 3'd4;
  localparam logic [2:0] CFG_SENSOR_MASK   = 3'd5;

  // Register reset values.
  localparam logic [19:0]        RST_MISALIGN_TIME = 20'd1000;
  localparam logic [19:0]        RST_STAB_TIME     = 20'd3000;
  localparam logic [19:0]        RST_LANDED_TIME   = 20'd15000;
  localparam logic [22:0]        RST_APOGEE_DROP   = 23'd100;
  localparam logic signed [23:0] RST_PYRO_LOCKOUT  = 24'sd50;
  localparam logic [4:0]         RST_SENSOR_MASK   = 5'd0;

  // GPS fix types above this one are RTK float or fix.
  localparam logic [2:0] GPS_MIN_FIX = 3'd3;

  // Ignition is floor(3 * peak / 5). With n = 3 * peak below 2^26, the product
  // n * ceil(2^27 / 5) shifted right by 27 gives the exact quotient, so the
  // factor 3 is folded into the multiplier constant.
  localparam int          IGN_SHIFT = 27;
  localparam logic [26:0] IGN_MULT  = 27'd80530638;

  // One accepted input beat.
  typedef struct packed {
    logic               action;
    logic [7:0]         requested_state;
    logic               data_ready;
    logic [19:0]        time_since_launch_ms;
    logic signed [23:0] altitude_cm;
    logic [2:0]         gps_fix_type;
    logic               pyro_continuity;
  } item_t;

endpackage

>>> rtl/flight_mode_sequencer_core.sv
// Flight-mode sequencer: phase stepping, apogee detection and pyro drive.
`timescale 1ns / 1ps

// The sequencer takes one beat per clock cycle, without gaps, while out_ready
// holds, for ticks and commands alike. Each beat lands in an input register;
// once the output register is free, the phase logic evaluates it against the
// sequencer state and writes both the new state and the result beat into the
// output register. The input register keeps accepting while a finished result
// waits for out_ready, and stalls only when both are full.
// The deepest path is the ignition-altitude product, a 23 by 27 bit multiply
// of the registered peak altitude that feeds the ignition register. Configuration
// writes are taken in any cycle, but should be issued only while no beat is in
// flight; indexes beyond the sensor mask register are ignored.
module flight_mode_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [7:0]         requested_state,
  input  logic               data_ready,
  input  logic [19:0]        time_since_launch_ms,
  input  logic signed [23:0] altitude_cm,
  input  logic [2:0]         gps_fix_type,
  input  logic               pyro_continuity,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         flight_state,
  output logic               pyro_fire,
  output logic [2:0]         status,
  output logic signed [23:0] ignition_altitude
);
  import fms_pkg::*;

  // Configuration registers.
  logic [19:0]        misalign_time_ms;
  logic [19:0]        stabilization_time_ms;
  logic [19:0]        landed_time_ms;
  logic [22:0]        apogee_drop_cm;
  logic signed [23:0] pyro_lockout_cm;
  logic [4:0]         sensor_fail_mask;

  // Sequencer state.
  logic [7:0]         phase, phase_next;
  logic signed [23:0] peak_altitude, peak_altitude_next;
  logic signed [23:0] ignition_level, ignition_level_next;
  logic               pyro_level, pyro_level_next;
  logic [2:0]         status_next;

  // Input register.
  item_t item;
  logic  item_valid;
  logic  item_move;

  logic [49:0]        ign_product;
  logic signed [23:0] ign_candidate;
  logic signed [25:0] alt_wide;
  logic signed [25:0] apogee_floor;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      misalign_time_ms      <= RST_MISALIGN_TIME;
      stabilization_time_ms <= RST_STAB_TIME;
      landed_time_ms        <= RST_LANDED_TIME;
      apogee_drop_cm        <= RST_APOGEE_DROP;
      pyro_lockout_cm       <= RST_PYRO_LOCKOUT;
      sensor_fail_mask      <= RST_SENSOR_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MISALIGN_TIME: misalign_time_ms      <= cfg_data[19:0];
        CFG_STAB_TIME:     stabilization_time_ms <= cfg_data[19:0];
        CFG_LANDED_TIME:   landed_time_ms        <= cfg_data[19:0];
        CFG_APOGEE_DROP:   apogee_drop_cm        <= cfg_data[22:0];
        CFG_PYRO_LOCKOUT:  pyro_lockout_cm       <= $signed(cfg_data);
        CFG_SENSOR_MASK:   sensor_fail_mask      <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // The input register moves forward whenever the result register is empty
  // or being emptied this cycle, so a stalled result does not stop intake
  // until the input register is occupied as well.
  assign item_move = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || item_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action               <= action;
      item.requested_state      <= requested_state;
      item.data_ready           <= data_ready;
      item.time_since_launch_ms <= time_since_launch_ms;
      item.altitude_cm          <= altitude_cm;
      item.gps_fix_type         <= gps_fix_type;
      item.pyro_continuity      <= pyro_continuity;
    end
  end

  // The peak never goes negative: it starts at zero, only rises on ticks and is
  // cleared to zero by a disarm command. When the apogee test passes, the peak is
  // the one already held, so the candidate is taken from the registered peak.
  assign ign_product   = {27'd0, peak_altitude[22:0]} * {23'd0, IGN_MULT};
  assign ign_candidate = $signed({1'b0, ign_product[IGN_SHIFT +: 23]});

  assign alt_wide     = {{2{item.altitude_cm[23]}}, item.altitude_cm};
  assign apogee_floor = $signed({2'b00, peak_altitude}) - $signed({3'b000, apogee_drop_cm});

  always_comb begin
    phase_next          = phase;
    peak_altitude_next  = peak_altitude;
    ignition_level_next = ignition_level;
    pyro_level_next     = pyro_level;
    status_next         = ST_OK;

    if (item.action == ACT_TICK) begin
      case (phase) inside
        PH_ARMED, [PH_TEST_FIRST:PH_TEST_LAST]: begin
          if (item.data_ready) pyro_level_next = 1'b0;
        end
        PH_MISALIGN: begin
          if (item.data_ready) pyro_level_next = 1'b0;
          if (item.time_since_launch_ms > misalign_time_ms) phase_next = PH_GUIDANCE;
        end
        PH_GUIDANCE: begin
          if (item.data_ready) pyro_level_next = 1'b0;
          if (item.time_since_launch_ms > stabilization_time_ms) begin
            phase_next = PH_RETURN_VERT;
          end
        end
        PH_RETURN_VERT: begin
          if (item.data_ready) begin
            pyro_level_next = 1'b0;
            if (item.altitude_cm > peak_altitude) peak_altitude_next = item.altitude_cm;
            if (alt_wide < apogee_floor) begin
              ignition_level_next = ign_candidate;
              phase_next          = PH_PAST_APOGEE;
            end
          end
        end
        PH_PAST_APOGEE, PH_LANDING_BURN: begin
          if (item.data_ready) begin
            if (ignition_level == '0 || item.altitude_cm > ignition_level) begin
              pyro_level_next = 1'b0;
            end else if (item.altitude_cm > pyro_lockout_cm) begin
              pyro_level_next = 1'b1;
              if (phase == PH_PAST_APOGEE) phase_next = PH_LANDING_BURN;
            end else begin
              pyro_level_next = 1'b0;
            end
          end
          if (phase == PH_LANDING_BURN && item.time_since_launch_ms > landed_time_ms) begin
            phase_next = PH_LANDED;
          end
        end
        PH_LANDED: begin
          pyro_level_next = 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      // Commands never touch the pyro line.
      if (item.requested_state == PH_ARMED) begin
        if (phase != PH_DISARMED) begin
          status_next = ST_BAD_TRANSITION;
        end else if (sensor_fail_mask != '0 || item.gps_fix_type <= GPS_MIN_FIX) begin
          status_next = ST_BAD_SENSORS;
        end else if (!item.pyro_continuity) begin
          status_next = ST_NO_CONTINUITY;
        end else begin
          phase_next = PH_ARMED;
        end
      end else if (item.requested_state == PH_DISARMED) begin
        peak_altitude_next  = '0;
        ignition_level_next = '0;
        phase_next          = PH_DISARMED;
      end else if (item.requested_state <= PH_LANDED ||
                   item.requested_state >= PH_TEST_FIRST) begin
        phase_next = item.requested_state;
      end else begin
        status_next = ST_BAD_STATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DISARMED;
      peak_altitude  <= '0;
      ignition_level <= '0;
      pyro_level     <= 1'b0;
    end else if (item_move) begin
      phase          <= phase_next;
      peak_altitude  <= peak_altitude_next;
      ignition_level <= ignition_level_next;
      pyro_level     <= pyro_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      flight_state      <= phase_next;
      pyro_fire         <= pyro_level_next;
      status            <= status_next;
      ignition_altitude <= ignition_level_next;
    end
  end

  // An empty result register must never hold off the input side.
  a_intake_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // The pyro line only rises on a tick processed in a firing phase.
  a_pyro_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(pyro_level) |-> $past(item_move && item.action == ACT_TICK &&
                               (phase == PH_PAST_APOGEE || phase == PH_LANDING_BURN)))
    else $error("pyro line rose outside a firing tick");

  // State holds while no beat is being processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !item_move |=> $stable(ignition_level) && $stable(phase) && $stable(peak_altitude))
    else $error("sequencer state changed without a beat");

  // The tracked peak is never negative.
  a_peak_sign: assert property (@(posedge clk) disable iff (rst)
    !peak_altitude[23])
    else $error("peak altitude went negative");

endmodule
